[rtl/core/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared constants, types and the arctangent table for the line-following
// steering datapath.
// ----------------------------------------------------------------------------
package lfs_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SHW = (CORDIC_STAGES > 2) ? $clog2(CORDIC_STAGES) : 1;

	// cordic datapath widths
	localparam int CW = 46;
	localparam int ZW = 36;

	localparam int POS_W = 40;
	localparam int ANG_W = 16;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_AX   = 3'd0,
		REG_LINE_AY   = 3'd1,
		REG_LINE_BX   = 3'd2,
		REG_LINE_BY   = 3'd3,
		REG_DELTA_MAX = 3'd4,
		REG_CORRIDOR  = 3'd5
	} cfg_reg_t;

	localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [19:0]   DEG64_Q30 = 20'sd292818;
	localparam logic [19:0]          INVK_Q20 = 20'd636751;
	localparam int PI_Q13 = 25736;
	localparam int TWO_PI_Q13 = 51472;
	localparam logic [31:0] CORRIDOR_RST = 32'd2560;

	typedef struct packed {
		logic signed [ANG_W-1:0] hd;
		logic                    degen;
		logic signed [ZW-1:0]    phi;
		logic signed [POS_W-1:0] d;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = 36'sd843314857;
				1: r = 36'sd497837829;
				2: r = 36'sd263043837;
				3: r = 36'sd133525159;
				4: r = 36'sd67021687;
				5: r = 36'sd33543516;
				6: r = 36'sd16775851;
				7: r = 36'sd8388437;
				8: r = 36'sd4194283;
				9: r = 36'sd2097149;
				default: r = (i > 30) ? '0 : ZW'((64'd1 << 30) >> i);
			endcase
			return r;
		end
	endfunction

endpackage

[rtl/core/lfs_cordic_cell.sv]
// ----------------------------------------------------------------------------
// lfs_cordic_cell
// One vectoring micro-rotation with a follower vector, registered, plus the
// side word that travels alongside.
// ----------------------------------------------------------------------------
module lfs_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [lfs_pkg::SHW-1:0]     shift,
	input  logic signed [lfs_pkg::ZW-1:0] atan,
	input  logic                        in_vld,
	input  logic signed [lfs_pkg::CW-1:0] in_x,
	input  logic signed [lfs_pkg::CW-1:0] in_y,
	input  logic signed [lfs_pkg::CW-1:0] in_px,
	input  logic signed [lfs_pkg::CW-1:0] in_py,
	input  logic signed [lfs_pkg::ZW-1:0] in_z,
	input  lfs_pkg::side_t              in_side,
	output logic                        out_vld,
	output logic signed [lfs_pkg::CW-1:0] out_x,
	output logic signed [lfs_pkg::CW-1:0] out_y,
	output logic signed [lfs_pkg::CW-1:0] out_px,
	output logic signed [lfs_pkg::CW-1:0] out_py,
	output logic signed [lfs_pkg::ZW-1:0] out_z,
	output lfs_pkg::side_t              out_side
);
	import lfs_pkg::*;

	logic signed [CW-1:0] xs, ys, pxs, pys;
	logic                 up;

	assign xs  = in_x >>> shift;
	assign ys  = in_y >>> shift;
	assign pxs = in_px >>> shift;
	assign pys = in_py >>> shift;
	assign up  = !in_y[CW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			if (up) begin
				out_x  <= in_x + ys;
				out_y  <= in_y - xs;
				out_px <= in_px + pys;
				out_py <= in_py - pxs;
				out_z  <= in_z + atan;
			end else begin
				out_x  <= in_x - ys;
				out_y  <= in_y + xs;
				out_px <= in_px - pys;
				out_py <= in_py + pxs;
				out_z  <= in_z - atan;
			end
		end
	end

endmodule

[rtl/core/line_following_steering_top.sv]
// ----------------------------------------------------------------------------
// line_following_steering_top
// Line-following heading controller: cross-track distance, desired heading,
// wrapped heading error and clamped steering command.
// ----------------------------------------------------------------------------
// One position word is taken every cycle while in_stall is low. The path
// runs through an input register and two chains of CORDIC cells, one that
// finds the line direction while rotating the position into the line
// frame, and one that takes the arctangent of distance over corridor, plus
// a two-stage split multiplier for gain removal and two stages of angle
// wrap and clamp. The whole pipe holds only while a finished word waits at
// the output under stall.
module line_following_steering_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lfs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [39:0]                  pos_x,
	input  logic signed [39:0]                  pos_y,
	input  logic signed [15:0]                  heading_deg,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [15:0]                  steer_angle,
	output logic signed [15:0]                  desired_heading,
	output logic signed [15:0]                  heading_error,
	output logic signed [39:0]                  cross_track,
	output logic                                degenerate
);
	import lfs_pkg::*;

	logic signed [39:0] line_ax_q, line_ay_q, line_bx_q, line_by_q;
	logic [14:0]        delta_max_q;
	logic [31:0]        corridor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_ax_q   <= '0;
			line_ay_q   <= '0;
			line_bx_q   <= '0;
			line_by_q   <= '0;
			delta_max_q <= '0;
			corridor_q  <= CORRIDOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_AX:   line_ax_q   <= cfg_data;
				REG_LINE_AY:   line_ay_q   <= cfg_data;
				REG_LINE_BX:   line_bx_q   <= cfg_data;
				REG_LINE_BY:   line_by_q   <= cfg_data;
				REG_DELTA_MAX: delta_max_q <= cfg_data[14:0];
				REG_CORRIDOR:  corridor_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// ---------------- input stage
	logic signed [40:0] dx, dy, vx, vy;
	logic               degen, neg;
	logic signed [CW-1:0] dxe, dye, vxe, vye;
	logic signed [ZW-1:0] off;

	assign dx = {line_bx_q[39], line_bx_q} - {line_ax_q[39], line_ax_q};
	assign dy = {line_by_q[39], line_by_q} - {line_ay_q[39], line_ay_q};
	assign vx = {pos_x[39], pos_x} - {line_ax_q[39], line_ax_q};
	assign vy = {pos_y[39], pos_y} - {line_ay_q[39], line_ay_q};
	assign degen = (dx == '0) && (dy == '0);
	assign neg = dx[40];
	assign dxe = CW'(dx);
	assign dye = CW'(dy);
	assign vxe = CW'(vx);
	assign vye = CW'(vy);
	assign off = !neg ? '0 : (dy[40] ? -PI_Q30 : PI_Q30);

	logic                 vld_s1;
	logic signed [CW-1:0] x_s1, y_s1, px_s1, py_s1;
	logic signed [ZW-1:0] z_s1;
	side_t                side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= neg ? -dxe : dxe;
			y_s1  <= neg ? -dye : dye;
			px_s1 <= neg ? -vxe : vxe;
			py_s1 <= neg ? -vye : vye;
			z_s1  <= off;
			side_s1.hd    <= heading_deg;
			side_s1.degen <= degen;
			side_s1.phi   <= '0;
			side_s1.d     <= '0;
		end
	end

	// ---------------- first chain: line direction, position into line frame
	logic                 c1_vld [0:CORDIC_STAGES];
	logic signed [CW-1:0] c1_x [0:CORDIC_STAGES];
	logic signed [CW-1:0] c1_y [0:CORDIC_STAGES];
	logic signed [CW-1:0] c1_px [0:CORDIC_STAGES];
	logic signed [CW-1:0] c1_py [0:CORDIC_STAGES];
	logic signed [ZW-1:0] c1_z [0:CORDIC_STAGES];
	side_t                c1_side [0:CORDIC_STAGES];

	assign c1_vld[0]  = vld_s1;
	assign c1_x[0]    = x_s1;
	assign c1_y[0]    = y_s1;
	assign c1_px[0]   = px_s1;
	assign c1_py[0]   = py_s1;
	assign c1_z[0]    = z_s1;
	assign c1_side[0] = side_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_c1
		lfs_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.shift    (SHW'(i)),
			.atan     (atan_entry(i)),
			.in_vld   (c1_vld[i]),
			.in_x     (c1_x[i]),
			.in_y     (c1_y[i]),
			.in_px    (c1_px[i]),
			.in_py    (c1_py[i]),
			.in_z     (c1_z[i]),
			.in_side  (c1_side[i]),
			.out_vld  (c1_vld[i+1]),
			.out_x    (c1_x[i+1]),
			.out_y    (c1_y[i+1]),
			.out_px   (c1_px[i+1]),
			.out_py   (c1_py[i+1]),
			.out_z    (c1_z[i+1]),
			.out_side (c1_side[i+1])
		);
	end

	// ---------------- gain removal, split into two partial products
	logic signed [CW-1:0] vy_f;
	logic [22:0]          lo;
	logic signed [CW-24:0] hi;
	assign vy_f = c1_py[CORDIC_STAGES];
	assign lo = vy_f[22:0];
	assign hi = vy_f[CW-1:23];

	logic                  vld_m1;
	logic [42:0]           plo_m1;
	logic signed [CW-3:0]  phi_prod_m1;
	side_t                 side_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
		end else if (en) begin
			vld_m1 <= c1_vld[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_m1        <= lo * INVK_Q20;
			phi_prod_m1   <= (CW-2)'(hi * $signed({1'b0, INVK_Q20}));
			side_m1.hd    <= c1_side[CORDIC_STAGES].hd;
			side_m1.degen <= c1_side[CORDIC_STAGES].degen;
			side_m1.phi   <= c1_z[CORDIC_STAGES];
			side_m1.d     <= c1_side[CORDIC_STAGES].d;
		end
	end

	logic signed [67:0] psum;
	logic signed [47:0] dr;
	logic signed [39:0] dsat;
	assign psum = (68'(phi_prod_m1) <<< 23) + $signed({25'd0, plo_m1}) + 68'sd524288;
	assign dr = 48'(psum >>> 20);
	always_comb begin
		if (dr > 48'sd549755813887) begin
			dsat = 40'sh7F_FFFF_FFFF;
		end else if (dr < -48'sd549755813888) begin
			dsat = 40'sh80_0000_0000;
		end else begin
			dsat = dr[39:0];
		end
	end

	logic                 vld_m2;
	logic signed [CW-1:0] x_m2, y_m2;
	side_t                side_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m2 <= 1'b0;
		end else if (en) begin
			vld_m2 <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_m2          <= $signed({{(CW-32){1'b0}}, corridor_q});
			y_m2          <= CW'(dsat);
			side_m2.hd    <= side_m1.hd;
			side_m2.degen <= side_m1.degen;
			side_m2.phi   <= side_m1.phi;
			side_m2.d     <= dsat;
		end
	end

	// ---------------- second chain: atan(d / corridor)
	logic                 c2_vld [0:CORDIC_STAGES];
	logic signed [CW-1:0] c2_x [0:CORDIC_STAGES];
	logic signed [CW-1:0] c2_y [0:CORDIC_STAGES];
	logic signed [CW-1:0] c2_px [0:CORDIC_STAGES];
	logic signed [CW-1:0] c2_py [0:CORDIC_STAGES];
	logic signed [ZW-1:0] c2_z [0:CORDIC_STAGES];
	side_t                c2_side [0:CORDIC_STAGES];

	assign c2_vld[0]  = vld_m2;
	assign c2_x[0]    = x_m2;
	assign c2_y[0]    = y_m2;
	assign c2_px[0]   = '0;
	assign c2_py[0]   = '0;
	assign c2_z[0]    = '0;
	assign c2_side[0] = side_m2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_c2
		lfs_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.shift    (SHW'(i)),
			.atan     (atan_entry(i)),
			.in_vld   (c2_vld[i]),
			.in_x     (c2_x[i]),
			.in_y     (c2_y[i]),
			.in_px    (c2_px[i]),
			.in_py    (c2_py[i]),
			.in_z     (c2_z[i]),
			.in_side  (c2_side[i]),
			.out_vld  (c2_vld[i+1]),
			.out_x    (c2_x[i+1]),
			.out_y    (c2_y[i+1]),
			.out_px   (c2_px[i+1]),
			.out_py   (c2_py[i+1]),
			.out_z    (c2_z[i+1]),
			.out_side (c2_side[i+1])
		);
	end

	// ---------------- desired heading and raw error
	side_t              side_c2;
	logic signed [37:0] des30, hdp, err30, des_r, err_r;
	assign side_c2 = c2_side[CORDIC_STAGES];
	assign des30 = 38'(side_c2.phi) - 38'(c2_z[CORDIC_STAGES]);
	assign hdp   = 38'(side_c2.hd * DEG64_Q30);
	assign err30 = des30 - hdp;
	assign des_r = (des30 + 38'sd65536) >>> 17;
	assign err_r = (err30 + 38'sd65536) >>> 17;

	logic               vld_f1, degen_f1;
	logic signed [23:0] des13_f1, err13_f1;
	logic signed [39:0] d_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
		end else if (en) begin
			vld_f1 <= c2_vld[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			des13_f1 <= des_r[23:0];
			err13_f1 <= err_r[23:0];
			d_f1     <= side_c2.d;
			degen_f1 <= side_c2.degen;
		end
	end

	// ---------------- wrap to [-pi, pi), clamp
	logic signed [23:0] t, cand, r, werr, dm, steer;
	logic signed [15:0] des_sat;

	always_comb begin
		t = err13_f1 + 24'(PI_Q13);
		r = '0;
		cand = '0;
		// a few periods cover the whole error range
		for (int k = -4; k <= 4; k++) begin
			cand = t - 24'(k * TWO_PI_Q13);
			if (cand >= 0 && cand < 24'sd51472) begin
				r = cand;
			end
		end
		werr = r - 24'(PI_Q13);
		dm = $signed({9'd0, delta_max_q});
		if (werr > dm) begin
			steer = dm;
		end else if (werr < -dm) begin
			steer = -dm;
		end else begin
			steer = werr;
		end
		if (des13_f1 > 24'sd32767) begin
			des_sat = 16'sh7FFF;
		end else if (des13_f1 < -24'sd32768) begin
			des_sat = 16'sh8000;
		end else begin
			des_sat = des13_f1[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degenerate      <= degen_f1;
			steer_angle     <= degen_f1 ? '0 : steer[15:0];
			desired_heading <= degen_f1 ? '0 : des_sat;
			heading_error   <= degen_f1 ? '0 : werr[15:0];
			cross_track     <= degen_f1 ? '0 : d_f1;
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line-following steering block: directed table
// over line setups and extremes, then random phases under bursty input and
// patterned output stall; a local predictor or typed word checks each result.
// ----------------------------------------------------------------------------
module tb_top;
	import lfs_pkg::*;

	typedef struct {
		longint ax, ay, bx, by, dm, cor;
	} line_setup_t;

	typedef struct packed {
		logic signed [15:0] steer;
		logic signed [15:0] des;
		logic signed [15:0] err;
		logic signed [39:0] ct;
		logic               degen;
	} steer_word_t;

	typedef struct {
		int          setup;
		longint      px, py, hd;
		bit          typed;
		steer_word_t want;
	} dir_row_t;

	localparam longint PI30 = 64'sd3373259426;
	localparam longint DEG64 = 64'sd292818;
	localparam longint INVK = 64'sd636751;
	localparam longint PI13 = 64'sd25736;
	localparam longint TWOPI13 = 64'sd51472;
	localparam longint P40MAX = 64'sd549755813887;
	localparam longint P40MIN = -64'sd549755813888;
	localparam int LATENCY = 2 * CORDIC_STAGES + 5;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [39:0] pos_x, pos_y, cross_track;
	logic signed [15:0] heading_deg, steer_angle, desired_heading, heading_error;
	logic degenerate;

	line_setup_t cur;
	steer_word_t steer_q[$];
	int errors = 0;
	bit hold_req = 0;
	bit gaps_on = 1;

	longint atan_tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149};

	line_following_steering_top dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("line_following_steering_top test failed");
		$finish;
	end

	function automatic longint micro_angle(int i);
		if (i < 10) return atan_tab[i];
		if (i > 30) return 0;
		return longint'(64'd1 << (30 - i));
	endfunction

	// vectoring of (x,y); (u,v) follows the same micro-rotations
	function automatic longint vector_angle(longint x, longint y, inout longint u,
			inout longint v);
		longint z, xs, ys, us, vs;
		z = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i; ys = y >>> i; us = u >>> i; vs = v >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; u += vs; v -= us; z += micro_angle(i);
			end else begin
				x -= ys; y += xs; u -= vs; v += us; z -= micro_angle(i);
			end
		end
		return z;
	endfunction

	function automatic longint clip(longint a, longint lo, longint hi);
		return a < lo ? lo : (a > hi ? hi : a);
	endfunction

	function automatic steer_word_t predict_steer(line_setup_t c, longint px,
			longint py, longint hd);
		steer_word_t r;
		longint dx, dy, vx, vy, off, phi, d, at, des30, err, cx, cy;
		r = '0;
		dx = c.bx - c.ax; dy = c.by - c.ay;
		vx = px - c.ax; vy = py - c.ay;
		off = 0;
		if (dx == 0 && dy == 0) begin
			r.degen = 1;
			return r;
		end
		if (dx < 0) begin
			off = (dy >= 0) ? PI30 : -PI30;
			dx = -dx; dy = -dy; vx = -vx; vy = -vy;
		end
		phi = vector_angle(dx, dy, vx, vy) + off;
		d = clip((vy * INVK + (64'sd1 <<< 19)) >>> 20, P40MIN, P40MAX);
		cx = 0; cy = 0;
		at = vector_angle(c.cor, d, cx, cy);
		des30 = phi - at;
		err = (des30 - hd * DEG64 + 65536) >>> 17;
		err = (err + PI13) % TWOPI13;
		if (err < 0) err += TWOPI13;
		err -= PI13;
		r.steer = clip(err, -c.dm, c.dm);
		r.des = clip((des30 + 65536) >>> 17, -32768, 32767);
		r.err = err;
		r.ct = d;
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t idx, longint val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[39:0];
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_setup(line_setup_t c);
		write_reg(REG_LINE_AX, c.ax);
		write_reg(REG_LINE_AY, c.ay);
		write_reg(REG_LINE_BX, c.bx);
		write_reg(REG_LINE_BY, c.by);
		write_reg(REG_DELTA_MAX, c.dm);
		write_reg(REG_CORRIDOR, c.cor);
		cur = c;
	endtask

	task automatic drain();
		while (steer_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	int burst_left = 0;

	// drives one word from the falling edge; in_valid stays high across a burst
	task automatic send_word(longint px, longint py, longint hd, bit typed,
			steer_word_t want);
		int gap;
		longint sx, sy, sh;
		sx = longint'($signed(px[39:0]));
		sy = longint'($signed(py[39:0]));
		sh = longint'($signed(hd[15:0]));
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1;
		pos_x <= px[39:0];
		pos_y <= py[39:0];
		heading_deg <= hd[15:0];
		do @(posedge clk); while (in_stall);
		steer_q.push_back(typed ? want : predict_steer(cur, sx, sy, sh));
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 0;
		burst_left = 0;
	endtask

	always @(posedge clk) begin
		steer_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (steer_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = steer_q.pop_front();
				if (steer_angle !== e.steer) begin
					$error("steer_angle exp %0d got %0d", e.steer, steer_angle); errors++;
				end
				if (desired_heading !== e.des) begin
					$error("desired_heading exp %0d got %0d", e.des, desired_heading);
					errors++;
				end
				if (heading_error !== e.err) begin
					$error("heading_error exp %0d got %0d", e.err, heading_error); errors++;
				end
				if (cross_track !== e.ct) begin
					$error("cross_track exp %0d got %0d", e.ct, cross_track); errors++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate exp %0d got %0d", e.degen, degenerate); errors++;
				end
			end
		end
	end

	// receiver stall pattern, cycling through randomly chosen modes; long hold on request
	initial begin
		int mode, n;
		out_stall = 0;
		forever begin
			mode = $urandom_range(0, 3);
			for (n = 0; n < 64; n++) begin
				@(negedge clk);
				if (hold_req) begin
					out_stall <= 1;
					repeat (300) @(negedge clk);
					hold_req = 0;
				end
				case (mode)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 8);
					default: out_stall <= (n[3:0] < 4);
				endcase
			end
		end
	end

	function automatic longint rand_pos();
		longint v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return v >>> 24;
			1: return v >>> 40;
			2: return $urandom_range(0, 1) ? P40MAX - (v & 255) : P40MIN + (v & 255);
			default: return longint'({{24{v[39]}}, v[39:0]});
		endcase
	endfunction

	function automatic longint rand_heading();
		if ($urandom_range(0, 7) == 0) return longint'($signed(16'($urandom)));
		return longint'($urandom_range(0, 46080)) - 23040;
	endfunction

	line_setup_t dir_setup[4];
	dir_row_t dir_rows[$];

	initial begin
		line_setup_t c;
		steer_word_t degen_word;
		int last_setup;
		arst_n = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; pos_x = '0; pos_y = '0; heading_deg = '0;
		cur = '{0, 0, 0, 0, 0, 2560};
		degen_word = '0;
		degen_word.degen = 1;

		// reset setup (degenerate), plain x line, left line with zero corridor,
		// extreme coordinates with oversized limit
		dir_setup[0] = '{0, 0, 0, 0, 0, 2560};
		dir_setup[1] = '{0, 0, 25600, 0, 25736, 2560};
		dir_setup[2] = '{1000, 500, -9000, 500, 0, 0};
		dir_setup[3] = '{P40MIN, P40MIN, P40MAX, P40MAX, 32767, 64'hFFFF_FFFF};

		dir_rows = '{
			'{0, 0, 0, 0, 1, degen_word},
			'{0, P40MAX, P40MIN, 23040, 1, degen_word},
			'{0, P40MIN, P40MAX, -32768, 1, degen_word},
			'{1, 0, 0, 0, 0, '0},
			'{1, 1280, 2560, 5760, 0, '0},
			'{1, 1280, -2560, -5760, 0, '0},
			'{1, 0, P40MAX, 23040, 0, '0},
			'{1, 0, P40MIN, -23040, 0, '0},
			'{1, 500, 0, 32767, 0, '0},
			'{1, 500, 0, -32768, 0, '0},
			'{2, 0, 500, 0, 0, '0},
			'{2, 0, 900, 11520, 0, '0},
			'{2, 0, 100, -11520, 0, '0},
			'{3, 0, 0, 0, 0, '0},
			'{3, P40MIN, P40MAX, 11520, 0, '0},
			'{3, P40MAX, P40MIN, -11520, 0, '0},
			'{3, P40MAX, P40MAX, 23040, 0, '0},
			'{3, P40MIN, P40MIN, -23040, 0, '0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		last_setup = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].setup != last_setup) begin
				idle_input();
				drain();
				load_setup(dir_setup[dir_rows[i].setup]);
				last_setup = dir_rows[i].setup;
			end
			send_word(dir_rows[i].px, dir_rows[i].py, dir_rows[i].hd,
				dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < 10; ph++) begin
			idle_input();
			drain();
			c.ax = rand_pos() >>> ($urandom_range(0, 1) * 16);
			c.ay = rand_pos() >>> ($urandom_range(0, 1) * 16);
			case ($urandom_range(0, 4))
				0: begin c.bx = c.ax; c.by = c.ay; end
				1: begin c.bx = c.ax; c.by = rand_pos(); end
				default: begin c.bx = rand_pos(); c.by = rand_pos(); end
			endcase
			case ($urandom_range(0, 3))
				0: c.dm = 0;
				1: c.dm = 25736;
				2: c.dm = 32767;
				default: c.dm = $urandom_range(0, 25736);
			endcase
			case ($urandom_range(0, 4))
				0: c.cor = 0;
				1: c.cor = 1;
				2: c.cor = 64'hFFFF_FFFF;
				default: c.cor = $urandom_range(1, 100000);
			endcase
			load_setup(c);
			gaps_on = (ph % 3 != 1);
			if (ph == 4) hold_req = 1;
			for (int k = 0; k < 95; k++) begin
				if ($urandom_range(0, 3) == 0)
					send_word(c.ax + ($urandom_range(0, 20000) - 10000),
						c.ay + ($urandom_range(0, 20000) - 10000), rand_heading(), 0, '0);
				else
					send_word(rand_pos(), rand_pos(), rand_heading(), 0, '0);
			end
		end

		idle_input();
		drain();
		if (errors == 0)
			$display("line_following_steering_top test passed");
		else
			$display("line_following_steering_top test failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/lfs_pkg.sv
rtl/core/lfs_cordic_cell.sv
rtl/core/line_following_steering_top.sv
tb/tb_top.sv
